// File: hw/rtl/assert_macros.svh
// Assertion helpers included by the vertex generator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: hw/rtl/uvsg_pkg.sv
package uvsg_pkg;

    localparam logic [7:0] MAX_DIVISIONS = 8'd255;
    localparam int CORDIC_STEPS = 16;

    // angle divider: one integer bit plus FRAC_BITS fraction bits
    localparam int FRAC_BITS  = 32;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = FRAC_BITS / DIV_BITS;

    localparam int CORDIC_LAT = CORDIC_STEPS + 1;
    localparam int MIX_LAT    = 4;
    localparam int SIDE_LEN   = DIV_STAGES + CORDIC_LAT + MIX_LAT;

    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

    localparam logic [1:0] CFG_RADIUS   = 2'd0;
    localparam logic [1:0] CFG_RINGS    = 2'd1;
    localparam logic [1:0] CFG_SEGMENTS = 2'd2;

    typedef struct packed {
        logic [15:0] base;
        logic        last_ring;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } side_t;

    // atan(2^-i) in 2^-32 turns
    function automatic logic signed [31:0] atan_turn(input int i);
        logic signed [31:0] a;
        case (i)
            0:  a = 32'sh20000000;
            1:  a = 32'sh12E4051D;
            2:  a = 32'sh09FB385B;
            3:  a = 32'sh051111D4;
            4:  a = 32'sh028B0D43;
            5:  a = 32'sh0145D7E1;
            6:  a = 32'sh00A2F61E;
            7:  a = 32'sh00517C55;
            8:  a = 32'sh0028BE53;
            9:  a = 32'sh00145F2E;
            10: a = 32'sh000A2F98;
            11: a = 32'sh000517CC;
            12: a = 32'sh00028BE6;
            13: a = 32'sh000145F3;
            14: a = 32'sh0000A2F9;
            15: a = 32'sh0000517C;
            16: a = 32'sh000028BE;
            17: a = 32'sh0000145F;
            18: a = 32'sh00000A2F;
            19: a = 32'sh00000517;
            20: a = 32'sh0000028B;
            21: a = 32'sh00000145;
            22: a = 32'sh000000A2;
            23: a = 32'sh00000051;
            default: a = 32'sh0;
        endcase
        return a;
    endfunction

    // round half up at bit s, then clamp to +-lim
    function automatic logic signed [63:0] rnd_sat(input logic signed [63:0] v,
                                                   input int s,
                                                   input logic signed [63:0] lim);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (s - 1))) >>> s;
        if (t > lim)
            t = lim;
        else if (t < -lim)
            t = -lim;
        return t;
    endfunction

    function automatic logic [7:0] count_of(input logic [7:0] v);
        logic [7:0] c;
        if (v == 8'd0)
            c = 8'd1;
        else if (v > MAX_DIVISIONS)
            c = MAX_DIVISIONS;
        else
            c = v;
        return c;
    endfunction

endpackage

// File: hw/rtl/uv_sphere_vertex_generator_core.sv
// Channel   Dir  Payload
// s_axis    in   tdata: ring_index, segment_index
// m_axis    out  tdata: pos, norm, tex, corners; tlast: last_of_point
// cfg       in   cfg_wr_en / cfg_index / cfg_data, write only
//
// The path from input accept to first result: input register, 8 divider stages,
// CORDIC_STEPS + 1 CORDIC stages, 4 product stages, output register.
// A point on the last ring gives one result; any other point gives two, which the
// output register sends in turn, holding the pipeline until the second is taken.
// Asynchronous active-low reset clears valid bits and loads register defaults.
// A stall at m_axis freezes the whole pipeline; s_tready drops with it.
`include "assert_macros.svh"

module uv_sphere_vertex_generator_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] ring_index, [15:8] segment_index
    input  logic [15:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z, [66:51] norm_x, [82:67] norm_y,
    // [98:83] norm_z, [115:99] tex_u, [132:116] tex_v, [148:133] corner_a,
    // [164:149] corner_b, [180:165] corner_c, [183:181] zero
    output logic [183:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int SL = uvsg_pkg::SIDE_LEN;
    localparam int DS = uvsg_pkg::DIV_STAGES;
    localparam int FB = uvsg_pkg::FRAC_BITS;

    logic [15:0] radius_reg;
    logic [7:0]  ring_cnt_reg, seg_cnt_reg;
    logic [7:0]  r_eff, s_eff;

    logic        en;
    logic        in_vld_reg;
    logic [7:0]  ring0_reg, seg0_reg;
    logic [7:0]  ring_in, seg_in;

    logic            vld_reg  [SL];
    uvsg_pkg::side_t side_reg [SL];
    uvsg_pkg::side_t side_first, side_tex;

    logic [FB:0]        quo_t, quo_p;
    logic signed [31:0] st, ct, sp, cp;
    logic signed [16:0] pos_x, pos_y, pos_z;
    logic signed [15:0] norm_x, norm_y, norm_z;
    logic [18:0]        tu_sum, tv_sum;

    logic        out_vld_reg, phase_reg;
    logic [16:0] px_reg, py_reg, pz_reg;
    logic [15:0] nx_reg, ny_reg, nz_reg;
    logic [16:0] tu_reg, tv_reg;
    logic [15:0] base_reg;
    logic        last_ring_reg;
    logic [15:0] ca, cb, cc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= 16'd256;
            ring_cnt_reg <= 8'd200;
            seg_cnt_reg  <= 8'd200;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                uvsg_pkg::CFG_RADIUS:   radius_reg   <= cfg_data;
                uvsg_pkg::CFG_RINGS:    ring_cnt_reg <= cfg_data[7:0];
                uvsg_pkg::CFG_SEGMENTS: seg_cnt_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign r_eff = uvsg_pkg::count_of(ring_cnt_reg);
    assign s_eff = uvsg_pkg::count_of(seg_cnt_reg);

    assign ring_in = (s_tdata[7:0]  > r_eff) ? r_eff : s_tdata[7:0];
    assign seg_in  = (s_tdata[15:8] > s_eff) ? s_eff : s_tdata[15:8];

    // whole pipeline moves unless the output register still has a result to send
    assign en       = !out_vld_reg || (m_tready && m_tlast);
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= 1'b0;
            for (int k = 0; k < SL; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            in_vld_reg <= s_tvalid;
            vld_reg[0] <= in_vld_reg;
            for (int k = 1; k < SL; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_vld_reg <= vld_reg[SL-1];
            phase_reg   <= 1'b0;
        end
        else if (m_tready)
        begin
            phase_reg <= 1'b1;
        end
    end

    always_comb
    begin
        side_first.base      = 16'(ring0_reg * ({1'b0, s_eff} + 9'd1) + 17'(seg0_reg));
        side_first.last_ring = (ring0_reg == r_eff);
        side_first.tex_u     = '0;
        side_first.tex_v     = '0;
        // round half up: (q17 + 1) / 2
        tu_sum = 19'(quo_p[FB:FB-17]) + 19'd1;
        tv_sum = 19'(quo_t[FB:FB-17]) + 19'd1;
        side_tex       = side_reg[DS-1];
        side_tex.tex_u = tu_sum[17:1];
        side_tex.tex_v = tv_sum[17:1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ring0_reg   <= ring_in;
            seg0_reg    <= seg_in;
            side_reg[0] <= side_first;
            for (int k = 1; k < SL; k++)
            begin
                if (k == DS)
                    side_reg[k] <= side_tex;
                else
                    side_reg[k] <= side_reg[k-1];
            end
            px_reg        <= pos_x;
            py_reg        <= pos_y;
            pz_reg        <= pos_z;
            nx_reg        <= norm_x;
            ny_reg        <= norm_y;
            nz_reg        <= norm_z;
            tu_reg        <= side_reg[SL-1].tex_u;
            tv_reg        <= side_reg[SL-1].tex_v;
            base_reg      <= side_reg[SL-1].base;
            last_ring_reg <= side_reg[SL-1].last_ring;
        end
    end

    uvsg_div u_div_theta (
        .clk (clk),
        .en  (en),
        .num (ring0_reg),
        .den (r_eff),
        .quo (quo_t)
    );

    uvsg_div u_div_phi (
        .clk (clk),
        .en  (en),
        .num (seg0_reg),
        .den (s_eff),
        .quo (quo_p)
    );

    // theta spans half a turn, phi a full turn (the integer bit wraps away)
    uvsg_cordic u_cordic_theta (
        .clk   (clk),
        .en    (en),
        .angle (quo_t[FB:1]),
        .sn    (st),
        .cs    (ct)
    );

    uvsg_cordic u_cordic_phi (
        .clk   (clk),
        .en    (en),
        .angle (quo_p[FB-1:0]),
        .sn    (sp),
        .cs    (cp)
    );

    uvsg_mix u_mix (
        .clk    (clk),
        .en     (en),
        .radius (radius_reg),
        .st     (st),
        .ct     (ct),
        .sp     (sp),
        .cp     (cp),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .norm_x (norm_x),
        .norm_y (norm_y),
        .norm_z (norm_z)
    );

    always_comb
    begin
        if (last_ring_reg)
        begin
            ca = '0;
            cb = '0;
            cc = '0;
        end
        else
        begin
            ca = 16'(base_reg + 16'(s_eff) + 16'd1);
            cb = phase_reg ? 16'(base_reg + 16'd1) : base_reg;
            cc = phase_reg ? base_reg : 16'(base_reg + 16'(s_eff));
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = last_ring_reg || phase_reg;
    assign m_tdata  = {3'b000, cc, cb, ca, tv_reg, tu_reg,
                       nz_reg, ny_reg, nx_reg, pz_reg, py_reg, px_reg};

    `ASSERT_PROP(a_ready_when_empty, clk, rst_n, !out_vld_reg |-> s_tready, "ready low with empty output")
    `ASSERT_PROP(a_second_follows, clk, rst_n, (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast), "second result missing")
    `ASSERT_PROP(a_accept_loads, clk, rst_n, (s_tvalid && s_tready) |=> in_vld_reg, "accepted item lost")
    `ASSERT_PROP(a_stall_holds, clk, rst_n, !en |=> $stable(vld_reg[SL-1]), "pipeline moved during stall")

endmodule

// File: hw/rtl/uvsg_div.sv
// Pipelined long division: quo = floor(num * 2^FRAC_BITS / den), num <= den.
module uvsg_div (
    input  logic        clk,
    input  logic        en,
    input  logic [7:0]  num,
    input  logic [7:0]  den,
    output logic [uvsg_pkg::FRAC_BITS:0] quo
);

    localparam int NB = uvsg_pkg::DIV_BITS;
    localparam int FB = uvsg_pkg::FRAC_BITS;
    localparam int NS = uvsg_pkg::DIV_STAGES;

    logic [7:0]  rem_reg [NS];
    logic [FB:0] quo_reg [NS];

    function automatic logic [NB+7:0] div_steps(input logic [7:0] rem,
                                                input logic [7:0] d);
        logic [8:0]    t;
        logic [7:0]    r;
        logic [NB-1:0] b;
        r = rem;
        b = '0;
        for (int k = 0; k < NB; k++)
        begin
            t = {r, 1'b0};
            if (t >= {1'b0, d})
            begin
                b[NB-1-k] = 1'b1;
                r = 8'(t - {1'b0, d});
            end
            else
            begin
                r = t[7:0];
            end
        end
        return {r, b};
    endfunction

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [7:0]    rem_in;
        logic [FB:0]   quo_in;
        logic [NB+7:0] res;
        logic [FB:0]   quo_next;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                quo_in = '0;
                quo_in[FB] = (num == den);
                rem_in = (num == den) ? 8'd0 : num;
            end
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        always_comb
        begin
            res = div_steps(rem_in, den);
            quo_next = quo_in;
            quo_next[FB-1-s*NB -: NB] = res[NB-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= res[NB+7:NB];
                quo_reg[s] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[NS-1];

endmodule

// File: hw/rtl/uvsg_cordic.sv
// Rotation CORDIC, one micro-rotation per stage, quadrant folded in at the end.
module uvsg_cordic (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        angle,
    output logic signed [31:0] sn,
    output logic signed [31:0] cs
);

    localparam int NS = uvsg_pkg::CORDIC_STEPS;

    logic signed [31:0] x_reg [NS];
    logic signed [31:0] y_reg [NS];
    logic signed [31:0] z_reg [NS];
    logic [1:0]         q_reg [NS];
    logic signed [31:0] sn_reg, cs_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_step
        logic signed [31:0] x_in, y_in, z_in;
        logic [1:0]         q_in;
        logic signed [31:0] x_next, y_next, z_next;

        if (i == 0)
        begin : g_first
            assign x_in = uvsg_pkg::INV_GAIN_Q30;
            assign y_in = '0;
            assign z_in = $signed({2'b00, angle[29:0]});
            assign q_in = angle[31:30];
        end
        else
        begin : g_rest
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign q_in = q_reg[i-1];
        end

        always_comb
        begin
            if (!z_in[31])
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - uvsg_pkg::atan_turn(i);
            end
            else
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + uvsg_pkg::atan_turn(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
                q_reg[i] <= q_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (q_reg[NS-1])
                2'd0:
                begin
                    cs_reg <= x_reg[NS-1];
                    sn_reg <= y_reg[NS-1];
                end
                2'd1:
                begin
                    cs_reg <= -y_reg[NS-1];
                    sn_reg <= x_reg[NS-1];
                end
                2'd2:
                begin
                    cs_reg <= -x_reg[NS-1];
                    sn_reg <= -y_reg[NS-1];
                end
                default:
                begin
                    cs_reg <= y_reg[NS-1];
                    sn_reg <= -x_reg[NS-1];
                end
            endcase
        end
    end

    assign sn = sn_reg;
    assign cs = cs_reg;

endmodule

// File: hw/rtl/uvsg_mix.sv
// Products, rounding and saturation: four register stages.
module uvsg_mix (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        radius,
    input  logic signed [31:0] st,
    input  logic signed [31:0] ct,
    input  logic signed [31:0] sp,
    input  logic signed [31:0] cp,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z
);

    localparam logic signed [63:0] POS_LIM  = 64'sd65535;
    localparam logic signed [63:0] NORM_LIM = 64'sd16384;

    // stage 1
    logic signed [48:0] p_rst_reg, p_rct_reg;
    logic signed [63:0] p_ss_reg, p_sc_reg;
    logic signed [31:0] ct1_reg, sp1_reg, cp1_reg;
    // stage 2
    logic signed [18:0] r0_reg;
    logic signed [31:0] sp2_reg, cp2_reg;
    logic signed [16:0] py2_reg;
    logic signed [15:0] nx2_reg, ny2_reg, nz2_reg;
    // stage 3
    logic signed [63:0] p_x_reg, p_z_reg;
    logic signed [16:0] py3_reg;
    logic signed [15:0] nx3_reg, ny3_reg, nz3_reg;
    // stage 4
    logic signed [16:0] px4_reg, py4_reg, pz4_reg;
    logic signed [15:0] nx4_reg, ny4_reg, nz4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rst_reg <= 49'($signed({1'b0, radius})) * 49'(st);
            p_rct_reg <= 49'($signed({1'b0, radius})) * 49'(ct);
            p_ss_reg  <= 64'(st) * 64'(sp);
            p_sc_reg  <= 64'(st) * 64'(cp);
            ct1_reg   <= ct;
            sp1_reg   <= sp;
            cp1_reg   <= cp;

            // ring radius is kept unclamped
            r0_reg  <= 19'(uvsg_pkg::rnd_sat(64'(p_rst_reg), 30, 64'sh3FFFFFFFFFFFFFFF));
            sp2_reg <= sp1_reg;
            cp2_reg <= cp1_reg;
            py2_reg <= 17'(uvsg_pkg::rnd_sat(64'(p_rct_reg), 30, POS_LIM));
            nx2_reg <= 16'(uvsg_pkg::rnd_sat(p_ss_reg, 46, NORM_LIM));
            ny2_reg <= 16'(uvsg_pkg::rnd_sat(64'(ct1_reg), 16, NORM_LIM));
            nz2_reg <= 16'(uvsg_pkg::rnd_sat(p_sc_reg, 46, NORM_LIM));

            p_x_reg <= 64'(r0_reg) * 64'(sp2_reg);
            p_z_reg <= 64'(r0_reg) * 64'(cp2_reg);
            py3_reg <= py2_reg;
            nx3_reg <= nx2_reg;
            ny3_reg <= ny2_reg;
            nz3_reg <= nz2_reg;

            px4_reg <= 17'(uvsg_pkg::rnd_sat(p_x_reg, 30, POS_LIM));
            pz4_reg <= 17'(uvsg_pkg::rnd_sat(p_z_reg, 30, POS_LIM));
            py4_reg <= py3_reg;
            nx4_reg <= nx3_reg;
            ny4_reg <= ny3_reg;
            nz4_reg <= nz3_reg;
        end
    end

    assign pos_x  = px4_reg;
    assign pos_y  = py4_reg;
    assign pos_z  = pz4_reg;
    assign norm_x = nx4_reg;
    assign norm_y = ny4_reg;
    assign norm_z = nz4_reg;

endmodule

// File: bench/uv_sphere_vertex_generator_core_tb.sv
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_core_tb;

    localparam int PIPE_LAT = 31;

    typedef struct packed {
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [15:0] corner_a;
        logic [15:0] corner_b;
        logic [15:0] corner_c;
        logic        last_of_point;
    } vertex_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // [7:0] ring_index, [15:8] segment_index
    logic [15:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // [16:0] pos_x ... [180:165] corner_c, [183:181] zero
    logic [183:0] m_tdata;
    logic         m_tlast;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    // shadow of the register file
    logic [15:0] radius_q;
    logic [7:0]  rings_q;
    logic [7:0]  segments_q;

    logic [15:0] point_queue[$];
    vertex_t     vertex_queue[$];
    int          fail_count;
    bit          src_idle_on;
    bit          sink_idle_on;
    bit          src_took;
    int          src_gap;
    int          sink_gap;
    int          hold_cycles;

    uv_sphere_vertex_generator_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #50ms;
        $display("uv_sphere_vertex_generator_core verification failed");
        $finish;
    end

    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint round_clamp(input longint v, input int s, input longint lim);
        longint t;
        t = (v + (64'sd1 <<< (s - 1))) >>> s;
        if (t > lim)
            t = lim;
        else if (t < -lim)
            t = -lim;
        return t;
    endfunction

    // rotation CORDIC on a 2^-32-turn angle, Q2.30 results
    task automatic cordic_sincos(input logic [31:0] ang, output longint sn, output longint cs);
        longint xv;
        longint yv;
        longint zv;
        longint dx;
        longint dy;
        longint at;
        xv = 652032874;
        yv = 0;
        zv = longint'(ang[29:0]);
        for (int i = 0; i < uvsg_pkg::CORDIC_STEPS && i < 24; i++)
        begin
            at = longint'(uvsg_pkg::atan_turn(i));
            dx = shr_floor(yv, i);
            dy = shr_floor(xv, i);
            if (zv >= 0)
            begin
                xv -= dx; yv += dy; zv -= at;
            end
            else
            begin
                xv += dx; yv -= dy; zv += at;
            end
        end
        case (ang[31:30])
            2'd0: begin cs = xv;  sn = yv;  end
            2'd1: begin cs = -yv; sn = xv;  end
            2'd2: begin cs = -xv; sn = -yv; end
            default: begin cs = yv; sn = -xv; end
        endcase
    endtask

    function automatic longint div_count(input logic [7:0] v);
        if (v == 0)
            return 1;
        return v;
    endfunction

    task automatic predict_vertices(input logic [15:0] pt);
        longint  nr;
        longint  ns;
        longint  ring;
        longint  seg;
        longint  rad;
        longint  st;
        longint  ct;
        longint  sp;
        longint  cp;
        longint  r0;
        longint  base;
        vertex_t v;
        nr = div_count(rings_q);
        ns = div_count(segments_q);
        ring = pt[7:0];
        seg = pt[15:8];
        rad = radius_q;
        if (ring > nr)
            ring = nr;
        if (seg > ns)
            seg = ns;
        cordic_sincos(32'((ring << 31) / nr), st, ct);
        cordic_sincos(32'((seg << 32) / ns), sp, cp);
        r0 = round_clamp(rad * st, 30, 64'sh7FFFFFFFFFFFFFFF);
        v.pos_x  = 17'(round_clamp(r0 * sp, 30, 65535));
        v.pos_y  = 17'(round_clamp(rad * ct, 30, 65535));
        v.pos_z  = 17'(round_clamp(r0 * cp, 30, 65535));
        v.norm_x = 16'(round_clamp(st * sp, 46, 16384));
        v.norm_y = 16'(round_clamp(ct, 16, 16384));
        v.norm_z = 16'(round_clamp(st * cp, 46, 16384));
        v.tex_u  = 17'(((seg << 17) + ns) / (2 * ns));
        v.tex_v  = 17'(((ring << 17) + nr) / (2 * nr));
        if (ring == nr)
        begin
            v.corner_a = '0;
            v.corner_b = '0;
            v.corner_c = '0;
            v.last_of_point = 1'b1;
            vertex_queue.insert(vertex_queue.size(), v);
        end
        else
        begin
            base = (ring * (ns + 1) + seg) & 16'hFFFF;
            v.corner_a = 16'(base + ns + 1);
            v.corner_b = 16'(base);
            v.corner_c = 16'(base + ns);
            v.last_of_point = 1'b0;
            vertex_queue.insert(vertex_queue.size(), v);
            v.corner_b = 16'(base + 1);
            v.corner_c = 16'(base);
            v.last_of_point = 1'b1;
            vertex_queue.insert(vertex_queue.size(), v);
        end
    endtask

    // source: an offered item stays put until it is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !src_took)
            begin
            end
            else if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (src_idle_on && $urandom_range(0, 9) == 0)
            begin
                src_gap <= $urandom_range(1, 7) - 1;
                s_tvalid <= 1'b0;
            end
            else if (point_queue.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= point_queue[0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // prediction happens at accept so it uses the live register values
    always @(posedge clk)
    begin
        src_took = 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            src_took = 1'b1;
            void'(point_queue.pop_front());
            predict_vertices(s_tdata);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 9) == 0)
            begin
                sink_gap <= $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        vertex_t got;
        vertex_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.pos_x = m_tdata[16:0];
            got.pos_y = m_tdata[33:17];
            got.pos_z = m_tdata[50:34];
            got.norm_x = m_tdata[66:51];
            got.norm_y = m_tdata[82:67];
            got.norm_z = m_tdata[98:83];
            got.tex_u = m_tdata[115:99];
            got.tex_v = m_tdata[132:116];
            got.corner_a = m_tdata[148:133];
            got.corner_b = m_tdata[164:149];
            got.corner_c = m_tdata[180:165];
            got.last_of_point = m_tlast;
            if (vertex_queue.size() == 0)
            begin
                $display("%0t: unexpected vertex %h", $realtime, got);
                fail_count++;
            end
            else
            begin
                want = vertex_queue.pop_front();
                if (got.pos_x !== want.pos_x)
                    $display("%0t: pos_x exp %h got %h", $realtime, want.pos_x, got.pos_x);
                if (got.pos_y !== want.pos_y)
                    $display("%0t: pos_y exp %h got %h", $realtime, want.pos_y, got.pos_y);
                if (got.pos_z !== want.pos_z)
                    $display("%0t: pos_z exp %h got %h", $realtime, want.pos_z, got.pos_z);
                if (got.norm_x !== want.norm_x)
                    $display("%0t: norm_x exp %h got %h", $realtime, want.norm_x, got.norm_x);
                if (got.norm_y !== want.norm_y)
                    $display("%0t: norm_y exp %h got %h", $realtime, want.norm_y, got.norm_y);
                if (got.norm_z !== want.norm_z)
                    $display("%0t: norm_z exp %h got %h", $realtime, want.norm_z, got.norm_z);
                if (got.tex_u !== want.tex_u)
                    $display("%0t: tex_u exp %h got %h", $realtime, want.tex_u, got.tex_u);
                if (got.tex_v !== want.tex_v)
                    $display("%0t: tex_v exp %h got %h", $realtime, want.tex_v, got.tex_v);
                if (got.corner_a !== want.corner_a)
                    $display("%0t: corner_a exp %h got %h", $realtime, want.corner_a,
                             got.corner_a);
                if (got.corner_b !== want.corner_b)
                    $display("%0t: corner_b exp %h got %h", $realtime, want.corner_b,
                             got.corner_b);
                if (got.corner_c !== want.corner_c)
                    $display("%0t: corner_c exp %h got %h", $realtime, want.corner_c,
                             got.corner_c);
                if (got.last_of_point !== want.last_of_point)
                    $display("%0t: last_of_point exp %b got %b", $realtime,
                             want.last_of_point, got.last_of_point);
                if (got !== want)
                    fail_count++;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            uvsg_pkg::CFG_RADIUS:   radius_q = val;
            uvsg_pkg::CFG_RINGS:    rings_q = val[7:0];
            uvsg_pkg::CFG_SEGMENTS: segments_q = val[7:0];
            default: ;
        endcase
    endtask

    task automatic drain_all();
        while (point_queue.size() > 0 || s_tvalid || vertex_queue.size() > 0)
            @(negedge clk);
        repeat (PIPE_LAT + 4) @(negedge clk);
    endtask

    task automatic queue_point(input int ring, input int seg);
        point_queue.insert(point_queue.size(), {8'(seg), 8'(ring)});
    endtask

    task automatic random_phase(input int n_points);
        int nr;
        int ns;
        nr = int'(div_count(rings_q));
        ns = int'(div_count(segments_q));
        for (int i = 0; i < n_points; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_point($urandom_range(0, 255), $urandom_range(0, 255));
            else if ($urandom_range(0, 7) == 0)
                queue_point(nr, $urandom_range(0, ns));
            else
                queue_point($urandom_range(0, nr), $urandom_range(0, ns));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = uvsg_pkg::CFG_RADIUS;
        cfg_data = '0;
        radius_q = 16'd256;
        rings_q = 8'd200;
        segments_q = 8'd200;
        fail_count = 0;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        src_took = 1'b0;
        src_gap = 0;
        sink_gap = 0;
        hold_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, poles, seams, out-of-range indexes
        queue_point(0, 0);
        queue_point(200, 0);
        queue_point(100, 50);
        queue_point(199, 200);
        queue_point(255, 255);
        queue_point(50, 150);
        drain_all();
        write_reg(uvsg_pkg::CFG_RADIUS, 16'hFFFF);
        write_reg(uvsg_pkg::CFG_RINGS, 16'd255);
        write_reg(uvsg_pkg::CFG_SEGMENTS, 16'd255);
        queue_point(0, 0);
        queue_point(128, 64);
        queue_point(254, 255);
        queue_point(255, 128);
        queue_point(127, 191);
        queue_point(1, 1);
        drain_all();
        write_reg(uvsg_pkg::CFG_RADIUS, 16'd1);
        write_reg(uvsg_pkg::CFG_RINGS, 16'd0);
        write_reg(uvsg_pkg::CFG_SEGMENTS, 16'd0);
        queue_point(0, 0);
        queue_point(1, 1);
        queue_point(0, 1);
        queue_point(170, 85);
        drain_all();

        // long receiver hold so the pipeline fills and backs up the input
        write_reg(uvsg_pkg::CFG_RADIUS, 16'd1000);
        write_reg(uvsg_pkg::CFG_RINGS, 16'd16);
        write_reg(uvsg_pkg::CFG_SEGMENTS, 16'd24);
        hold_cycles = 300;
        random_phase(120);
        drain_all();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(uvsg_pkg::CFG_RADIUS, 16'($urandom_range(1, 65535)));
            write_reg(uvsg_pkg::CFG_RINGS, 16'($urandom_range(0, 255)));
            write_reg(uvsg_pkg::CFG_SEGMENTS, 16'($urandom_range(0, 255)));
            random_phase(230);
            drain_all();
        end

        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        write_reg(uvsg_pkg::CFG_RADIUS, 16'd256);
        write_reg(uvsg_pkg::CFG_RINGS, 16'd2);
        write_reg(uvsg_pkg::CFG_SEGMENTS, 16'd3);
        random_phase(130);
        drain_all();

        if (fail_count == 0)
            $display("uv_sphere_vertex_generator_core verification clean");
        else
            $display("uv_sphere_vertex_generator_core verification failed");
        $finish;
    end

endmodule
